/* src/p2fl_pkg.sv */
// Package with the allocator's constants, word types and a small helper function.
package p2fl_pkg;

	localparam int PageBytes   = 8192;
	localparam int MinBlock    = 64;
	localparam int NumPages    = 16;
	localparam int HeaderBytes = 40;

	localparam int NumClasses  = 8;
	localparam int BlkPerPage  = PageBytes / MinBlock;
	localparam int TotalBlocks = NumPages * BlkPerPage;
	localparam int IdxW        = $clog2(TotalBlocks);
	localparam int PgW         = $clog2(NumPages);
	localparam int ClsW        = $clog2(NumClasses);
	localparam int CntW        = $clog2(BlkPerPage) + 1;
	localparam int BlkShift    = $clog2(MinBlock);
	localparam int PageShift   = $clog2(PageBytes);
	localparam int NeedW       = 14;

	typedef struct packed {
		logic        kind;
		logic [12:0] req_bytes;
		logic [16:0] free_addr;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [16:0] block_addr;
		logic [4:0]  data_pages_used;
		logic        page_released;
	} rsp_t;

	// One entry of the link store: free mark, link valid, next block index.
	typedef struct packed {
		logic            free;
		logic            valid;
		logic [IdxW-1:0] link;
	} link_t;

	typedef enum logic [1:0] {
		PG_FREE,
		PG_CTRL,
		PG_DATA
	} pg_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CTRL,
		S_CLASS,
		S_CARVE,
		S_POP_RD,
		S_POP_WR,
		S_FDEC,
		S_FCHK,
		S_WALK_RD,
		S_WALK_CHK,
		S_WALK_END,
		S_DONE
	} state_t;

	localparam logic KindAlloc = 1'b0;

	// Smallest class whose block holds the need; the top bit flags a fit.
	function automatic logic [ClsW:0] pick_class(input logic [NeedW-1:0] need);
		logic [ClsW:0] r;
		r = '0;
		for (int c = NumClasses - 1; c >= 0; c--) begin
			if ((NeedW'(MinBlock) << c) >= need) begin
				r = {1'b1, ClsW'(c)};
			end
		end
		return r;
	endfunction

endpackage

/* src/p2fl_link_ram.sv */
// Link store: per block free mark and next-link word, one write and one read port.
module p2fl_link_ram (
	input  logic                     clk,
	input  logic                     we,
	input  logic [p2fl_pkg::IdxW-1:0] waddr,
	input  p2fl_pkg::link_t          wdata,
	input  logic                     re,
	input  logic [p2fl_pkg::IdxW-1:0] raddr,
	output p2fl_pkg::link_t          rdata
);

	p2fl_pkg::link_t mem_q [p2fl_pkg::TotalBlocks];
	p2fl_pkg::link_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/power_of_two_free_list_allocator.sv */
// Top level: command sequencer, page table and class heads of the block allocator.
//
// One command word is taken when start is high and busy is low; busy stays high through
// the single cycle in which the result word appears with done high, and the next word can
// be taken in the cycle after that. Every access to the block link store goes through its
// single read and single write port: an allocate from a non-empty list reads the head
// block's link and then writes it back marked in use, one that first cuts a page writes a
// link for every block of the new page (up to 128) before that, a free that keeps its page
// reads the block's link and pushes the block, and a free that returns a page walks the
// class list, reading each entry and relinking around the blocks of that page, and then
// closes the walk. Results cannot be held off by the receiver.
module power_of_two_free_list_allocator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  p2fl_pkg::req_t   cmd,
	output logic             busy,
	output logic             done,
	output p2fl_pkg::rsp_t   result
);

	localparam int IdxW = p2fl_pkg::IdxW;
	localparam int PgW  = p2fl_pkg::PgW;
	localparam int ClsW = p2fl_pkg::ClsW;
	localparam int CntW = p2fl_pkg::CntW;

	p2fl_pkg::state_t state_q, state_d;
	p2fl_pkg::req_t   req_q;

	logic [IdxW-1:0]  class_head_q [p2fl_pkg::NumClasses];
	logic             head_valid_q [p2fl_pkg::NumClasses];
	p2fl_pkg::pg_state_t page_state_q [p2fl_pkg::NumPages];
	logic [ClsW-1:0]  page_class_q [p2fl_pkg::NumPages];
	logic [CntW-1:0]  page_cnt_q [p2fl_pkg::NumPages];
	logic [4:0]       pages_used_q;
	logic             table_ready_q;
	logic [PgW-1:0]   ctrl_page_q;

	logic [ClsW-1:0]  cls_q;
	logic [PgW-1:0]   pg_q;
	logic [IdxW-1:0]  idx_q;
	logic [IdxW-1:0]  car_i_q;
	logic [CntW-1:0]  car_rem_q;
	logic [IdxW-1:0]  cur_q, prev_q;
	logic             cur_v_q, prev_v_q;
	logic             ok_q, rel_q;
	logic [16:0]      addr_q;

	logic             mem_we, mem_re;
	logic [IdxW-1:0]  mem_waddr, mem_raddr;
	p2fl_pkg::link_t  mem_wdata, mem_rdata;

	// Lowest free page by priority over the page table.
	logic             pg_found;
	logic [PgW-1:0]   pg_low;
	always_comb begin
		pg_found = 1'b0;
		pg_low   = '0;
		for (int p = p2fl_pkg::NumPages - 1; p >= 0; p--) begin
			if (page_state_q[p] == p2fl_pkg::PG_FREE) begin
				pg_found = 1'b1;
				pg_low   = PgW'(p);
			end
		end
	end

	logic [ClsW:0]    cls_pick;
	assign cls_pick = p2fl_pkg::pick_class(p2fl_pkg::NeedW'(req_q.req_bytes)
		+ p2fl_pkg::NeedW'(p2fl_pkg::HeaderBytes));

	// Free address decode.
	logic [16:0]      blk;
	logic             addr_ge;
	logic [PgW-1:0]   f_pg;
	logic [ClsW-1:0]  f_cls;
	logic [12:0]      f_mask;
	logic             f_ok;
	assign addr_ge = req_q.free_addr >= 17'(p2fl_pkg::HeaderBytes);
	assign blk     = req_q.free_addr - 17'(p2fl_pkg::HeaderBytes);
	assign f_pg    = blk[p2fl_pkg::PageShift +: PgW];
	assign f_cls   = page_class_q[f_pg];
	assign f_mask  = (13'(p2fl_pkg::MinBlock) << f_cls) - 13'd1;
	assign f_ok    = addr_ge && (page_state_q[f_pg] == p2fl_pkg::PG_DATA)
		&& ((blk[12:0] & f_mask) == 13'd0);

	logic [CntW-1:0]  nb_cls;
	logic [CntW:0]    cnt_inc;
	logic             release_pg;
	assign nb_cls     = CntW'(p2fl_pkg::BlkPerPage) >> cls_q;
	assign cnt_inc    = {1'b0, page_cnt_q[pg_q]} + 1'b1;
	assign release_pg = cnt_inc >= {1'b0, nb_cls};

	logic [IdxW-1:0]  step;
	assign step = IdxW'(1) << cls_q;

	logic             cur_in_pg;
	assign cur_in_pg = cur_q[IdxW-1 -: PgW] == pg_q;

	p2fl_link_ram u_links (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			p2fl_pkg::S_IDLE: begin
				if (start) begin
					state_d = (cmd.kind == p2fl_pkg::KindAlloc) ? p2fl_pkg::S_CTRL
						: p2fl_pkg::S_FDEC;
				end
			end
			p2fl_pkg::S_CTRL: begin
				if ((!table_ready_q && !pg_found) || !cls_pick[ClsW]) begin
					state_d = p2fl_pkg::S_DONE;
				end else begin
					state_d = p2fl_pkg::S_CLASS;
				end
			end
			p2fl_pkg::S_CLASS: begin
				if (head_valid_q[cls_q]) begin
					state_d = p2fl_pkg::S_POP_RD;
				end else if (pg_found) begin
					state_d = p2fl_pkg::S_CARVE;
				end else begin
					state_d = p2fl_pkg::S_DONE;
				end
			end
			p2fl_pkg::S_CARVE: begin
				if (car_rem_q == CntW'(1)) begin
					state_d = p2fl_pkg::S_POP_RD;
				end
			end
			p2fl_pkg::S_POP_RD:   state_d = p2fl_pkg::S_POP_WR;
			p2fl_pkg::S_POP_WR:   state_d = p2fl_pkg::S_DONE;
			p2fl_pkg::S_FDEC:     state_d = f_ok ? p2fl_pkg::S_FCHK : p2fl_pkg::S_DONE;
			p2fl_pkg::S_FCHK: begin
				if (!mem_rdata.free && release_pg) begin
					state_d = p2fl_pkg::S_WALK_RD;
				end else begin
					state_d = p2fl_pkg::S_DONE;
				end
			end
			p2fl_pkg::S_WALK_RD: begin
				state_d = cur_v_q ? p2fl_pkg::S_WALK_CHK : p2fl_pkg::S_WALK_END;
			end
			p2fl_pkg::S_WALK_CHK: state_d = p2fl_pkg::S_WALK_RD;
			p2fl_pkg::S_WALK_END: state_d = p2fl_pkg::S_DONE;
			p2fl_pkg::S_DONE:     state_d = p2fl_pkg::S_IDLE;
			default:              state_d = p2fl_pkg::S_IDLE;
		endcase
	end

	// Link store accesses.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			p2fl_pkg::S_CARVE: begin
				mem_we          = 1'b1;
				mem_waddr       = car_i_q;
				mem_wdata.free  = 1'b1;
				mem_wdata.valid = car_rem_q != CntW'(1);
				mem_wdata.link  = (car_rem_q != CntW'(1)) ? car_i_q + step : '0;
			end
			p2fl_pkg::S_POP_RD: begin
				mem_re    = 1'b1;
				mem_raddr = class_head_q[cls_q];
			end
			p2fl_pkg::S_POP_WR: begin
				mem_we         = 1'b1;
				mem_waddr      = idx_q;
				mem_wdata      = mem_rdata;
				mem_wdata.free = 1'b0;
			end
			p2fl_pkg::S_FDEC: begin
				mem_re    = f_ok;
				mem_raddr = blk[p2fl_pkg::BlkShift +: IdxW];
			end
			p2fl_pkg::S_FCHK: begin
				mem_we          = !mem_rdata.free;
				mem_waddr       = idx_q;
				mem_wdata.free  = 1'b1;
				mem_wdata.valid = head_valid_q[cls_q];
				mem_wdata.link  = class_head_q[cls_q];
			end
			p2fl_pkg::S_WALK_RD: begin
				mem_re    = cur_v_q;
				mem_raddr = cur_q;
			end
			p2fl_pkg::S_WALK_CHK: begin
				mem_we          = !cur_in_pg && prev_v_q;
				mem_waddr       = prev_q;
				mem_wdata.free  = 1'b1;
				mem_wdata.valid = 1'b1;
				mem_wdata.link  = cur_q;
			end
			p2fl_pkg::S_WALK_END: begin
				mem_we         = prev_v_q;
				mem_waddr      = prev_q;
				mem_wdata.free = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= p2fl_pkg::S_IDLE;
			pages_used_q  <= '0;
			table_ready_q <= 1'b0;
			ctrl_page_q   <= '0;
			for (int c = 0; c < p2fl_pkg::NumClasses; c++) begin
				class_head_q[c] <= '0;
				head_valid_q[c] <= 1'b0;
			end
			for (int p = 0; p < p2fl_pkg::NumPages; p++) begin
				page_state_q[p] <= p2fl_pkg::PG_FREE;
				page_class_q[p] <= '0;
				page_cnt_q[p]   <= '0;
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				p2fl_pkg::S_CTRL: begin
					if (!table_ready_q && pg_found) begin
						page_state_q[pg_low] <= p2fl_pkg::PG_CTRL;
						ctrl_page_q          <= pg_low;
						table_ready_q        <= 1'b1;
					end
				end
				p2fl_pkg::S_CLASS: begin
					if (!head_valid_q[cls_q] && pg_found) begin
						class_head_q[cls_q]  <= {pg_low, (IdxW-PgW)'(0)};
						head_valid_q[cls_q]  <= 1'b1;
						page_cnt_q[pg_low]   <= nb_cls;
						page_class_q[pg_low] <= cls_q;
						page_state_q[pg_low] <= p2fl_pkg::PG_DATA;
						pages_used_q         <= pages_used_q + 5'd1;
					end
				end
				p2fl_pkg::S_POP_WR: begin
					head_valid_q[cls_q] <= mem_rdata.valid;
					class_head_q[cls_q] <= mem_rdata.link;
					if (page_cnt_q[idx_q[IdxW-1 -: PgW]] != '0) begin
						page_cnt_q[idx_q[IdxW-1 -: PgW]] <=
							page_cnt_q[idx_q[IdxW-1 -: PgW]] - 1'b1;
					end
				end
				p2fl_pkg::S_FCHK: begin
					if (!mem_rdata.free) begin
						if (release_pg) begin
							// The walk starts at the block just pushed.
							head_valid_q[cls_q] <= 1'b0;
							page_state_q[pg_q]  <= p2fl_pkg::PG_FREE;
							page_cnt_q[pg_q]    <= '0;
							if (pages_used_q != '0) begin
								pages_used_q <= pages_used_q - 5'd1;
							end
						end else begin
							class_head_q[cls_q] <= idx_q;
							head_valid_q[cls_q] <= 1'b1;
							page_cnt_q[pg_q]    <= cnt_inc[CntW-1:0];
						end
					end
				end
				p2fl_pkg::S_WALK_CHK: begin
					if (!cur_in_pg && !prev_v_q) begin
						class_head_q[cls_q] <= cur_q;
						head_valid_q[cls_q] <= 1'b1;
					end
				end
				p2fl_pkg::S_WALK_END: begin
					// With no data page left the control page is freed, the table is marked not ready and every class list is emptied.
					if (pages_used_q == '0) begin
						page_state_q[ctrl_page_q] <= p2fl_pkg::PG_FREE;
						table_ready_q             <= 1'b0;
						ctrl_page_q               <= '0;
						for (int c = 0; c < p2fl_pkg::NumClasses; c++) begin
							head_valid_q[c] <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the current command.
	always_ff @(posedge clk) begin
		case (state_q)
			p2fl_pkg::S_IDLE: begin
				req_q  <= cmd;
				ok_q   <= 1'b0;
				rel_q  <= 1'b0;
				addr_q <= '0;
			end
			p2fl_pkg::S_CTRL: begin
				cls_q <= cls_pick[ClsW-1:0];
			end
			p2fl_pkg::S_CLASS: begin
				car_i_q   <= {pg_low, (IdxW-PgW)'(0)};
				car_rem_q <= nb_cls;
			end
			p2fl_pkg::S_CARVE: begin
				car_i_q   <= car_i_q + step;
				car_rem_q <= car_rem_q - 1'b1;
			end
			p2fl_pkg::S_POP_RD: begin
				idx_q <= class_head_q[cls_q];
			end
			p2fl_pkg::S_POP_WR: begin
				ok_q   <= 1'b1;
				addr_q <= {idx_q, p2fl_pkg::BlkShift'(0)} + 17'(p2fl_pkg::HeaderBytes);
			end
			p2fl_pkg::S_FDEC: begin
				pg_q  <= f_pg;
				cls_q <= f_cls;
				idx_q <= blk[p2fl_pkg::BlkShift +: IdxW];
			end
			p2fl_pkg::S_FCHK: begin
				ok_q     <= !mem_rdata.free;
				rel_q    <= !mem_rdata.free && release_pg;
				cur_q    <= idx_q;
				cur_v_q  <= 1'b1;
				prev_v_q <= 1'b0;
			end
			p2fl_pkg::S_WALK_CHK: begin
				if (!cur_in_pg) begin
					prev_q   <= cur_q;
					prev_v_q <= 1'b1;
				end
				cur_q   <= mem_rdata.link;
				cur_v_q <= mem_rdata.valid;
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != p2fl_pkg::S_IDLE;
	assign done = state_q == p2fl_pkg::S_DONE;

	always_comb begin
		result.ok              = ok_q;
		result.block_addr      = addr_q;
		result.data_pages_used = pages_used_q;
		result.page_released   = rel_q;
	end

endmodule

/* tb/sv/tb_power_of_two_free_list_allocator.sv */
// Self-checking testbench for the power-of-two free-list allocator.
module tb_power_of_two_free_list_allocator;
	import p2fl_pkg::*;

	localparam logic KindFree = 1'b1;
	localparam int   IdleLimit = 40000;

	typedef struct packed {
		logic  kind;
		int    req;
		int    addr;
		logic  typed;
		rsp_t  want;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	req_t cmd;
	logic busy;
	logic done;
	rsp_t result;

	power_of_two_free_list_allocator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// Shadow copy of the allocator state.
	int        cls_head [NumClasses];
	bit        cls_head_ok [NumClasses];
	int        blk_next [TotalBlocks];
	bit        blk_next_ok [TotalBlocks];
	bit        blk_is_free [TotalBlocks];
	pg_state_t pg_state [NumPages];
	int        pg_class [NumPages];
	int        pg_free_cnt [NumPages];
	int        data_pages;
	bit        ctrl_taken;
	int        ctrl_pg;

	rsp_t      pending_rsp [$];
	int        live_addr [$];
	int        dead_addr [$];
	int        errors;
	int        n_words;
	int        n_allocs;
	int        n_frees;
	int        n_releases;
	int        n_refused;
	int        idle_cycles;
	bit        no_gaps;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int first_free_page();
		for (int p = 0; p < NumPages; p++) begin
			if (pg_state[p] == PG_FREE) begin
				return p;
			end
		end
		return -1;
	endfunction

	function automatic void carve(int p, int c);
		int stride;
		int nblk;
		int base;
		int i;
		stride = 1 << c;
		nblk = BlkPerPage / stride;
		base = p * BlkPerPage;
		for (int k = 0; k < nblk; k++) begin
			i = base + k * stride;
			blk_is_free[i] = 1'b1;
			blk_next_ok[i] = (k + 1 < nblk);
			blk_next[i] = (k + 1 < nblk) ? i + stride : 0;
		end
		cls_head[c] = base;
		cls_head_ok[c] = 1'b1;
		pg_free_cnt[p] = nblk;
		pg_class[p] = c;
		pg_state[p] = PG_DATA;
		data_pages++;
	endfunction

	// Drops every block of page p from the class list, keeping the others in order.
	function automatic void drop_page_blocks(int p, int c);
		int cur;
		int prv;
		int nxt;
		bit cur_ok;
		bit prv_ok;
		bit nxt_ok;
		cur = cls_head[c];
		cur_ok = cls_head_ok[c];
		prv = 0;
		prv_ok = 1'b0;
		cls_head_ok[c] = 1'b0;
		for (int n = 0; n < TotalBlocks && cur_ok; n++) begin
			nxt = blk_next[cur];
			nxt_ok = blk_next_ok[cur];
			if (cur / BlkPerPage != p) begin
				if (prv_ok) begin
					blk_next[prv] = cur;
					blk_next_ok[prv] = 1'b1;
				end else begin
					cls_head[c] = cur;
					cls_head_ok[c] = 1'b1;
				end
				prv = cur;
				prv_ok = 1'b1;
			end
			cur = nxt;
			cur_ok = nxt_ok;
		end
		if (prv_ok) begin
			blk_next_ok[prv] = 1'b0;
		end
	endfunction

	function automatic void clear_shadow();
		for (int c = 0; c < NumClasses; c++) begin
			cls_head[c] = 0;
			cls_head_ok[c] = 1'b0;
		end
		for (int i = 0; i < TotalBlocks; i++) begin
			blk_next[i] = 0;
			blk_next_ok[i] = 1'b0;
			blk_is_free[i] = 1'b0;
		end
		for (int p = 0; p < NumPages; p++) begin
			pg_state[p] = PG_FREE;
			pg_class[p] = 0;
			pg_free_cnt[p] = 0;
		end
		data_pages = 0;
		ctrl_taken = 1'b0;
		ctrl_pg = 0;
	endfunction

	function automatic rsp_t serve_request(req_t w);
		rsp_t r;
		int p;
		int c;
		int need;
		int idx;
		int blk;
		int bsize;
		bit go;
		r = '0;
		if (w.kind == KindAlloc) begin
			go = 1'b1;
			if (!ctrl_taken) begin
				p = first_free_page();
				if (p < 0) begin
					go = 1'b0;
				end else begin
					pg_state[p] = PG_CTRL;
					ctrl_pg = p;
					ctrl_taken = 1'b1;
				end
			end
			c = -1;
			need = int'(w.req_bytes) + HeaderBytes;
			if (go) begin
				for (int k = NumClasses - 1; k >= 0; k--) begin
					if ((MinBlock << k) >= need) begin
						c = k;
					end
				end
			end
			if (c >= 0 && !cls_head_ok[c]) begin
				p = first_free_page();
				if (p >= 0) begin
					carve(p, c);
				end
			end
			if (c >= 0 && cls_head_ok[c]) begin
				idx = cls_head[c];
				p = idx / BlkPerPage;
				cls_head_ok[c] = blk_next_ok[idx];
				cls_head[c] = blk_next[idx];
				blk_is_free[idx] = 1'b0;
				if (pg_free_cnt[p] > 0) begin
					pg_free_cnt[p]--;
				end
				r.ok = 1'b1;
				r.block_addr = 17'(idx * MinBlock + HeaderBytes);
			end
		end else if (int'(w.free_addr) >= HeaderBytes) begin
			blk = int'(w.free_addr) - HeaderBytes;
			p = blk / PageBytes;
			if (p < NumPages && pg_state[p] == PG_DATA) begin
				c = pg_class[p];
				bsize = MinBlock << c;
				idx = blk / MinBlock;
				if ((blk % PageBytes) % bsize == 0 && !blk_is_free[idx]) begin
					blk_next[idx] = cls_head[c];
					blk_next_ok[idx] = cls_head_ok[c];
					cls_head[c] = idx;
					cls_head_ok[c] = 1'b1;
					blk_is_free[idx] = 1'b1;
					pg_free_cnt[p]++;
					r.ok = 1'b1;
					if (pg_free_cnt[p] >= PageBytes / bsize) begin
						drop_page_blocks(p, c);
						pg_state[p] = PG_FREE;
						pg_free_cnt[p] = 0;
						if (data_pages > 0) begin
							data_pages--;
						end
						r.page_released = 1'b1;
					end
					if (data_pages == 0) begin
						pg_state[ctrl_pg] = PG_FREE;
						ctrl_taken = 1'b0;
						ctrl_pg = 0;
						for (int k = 0; k < NumClasses; k++) begin
							cls_head_ok[k] = 1'b0;
						end
					end
				end
			end
		end
		r.data_pages_used = 5'(data_pages);
		return r;
	endfunction

	// Drives one command word and waits until the block takes it.
	task automatic issue(req_t w, bit typed, rsp_t want);
		rsp_t got;
		if (!no_gaps) begin
			while ($urandom_range(99) < 6) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		cmd <= w;
		do begin
			@(posedge clk);
		end while (busy);
		got = serve_request(w);
		pending_rsp.push_back(typed ? want : got);
		if (w.kind == KindAlloc) begin
			n_allocs++;
			if (got.ok) begin
				live_addr.push_back(int'(got.block_addr));
			end else begin
				n_refused++;
			end
		end else begin
			n_frees++;
			if (got.page_released) begin
				n_releases++;
			end
		end
		n_words++;
	endtask

	task automatic issue_checked(logic kind, int req, int addr);
		req_t w;
		w.kind = kind;
		w.req_bytes = 13'(req);
		w.free_addr = 17'(addr);
		issue(w, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result word with nothing outstanding");
				errors++;
			end else begin
				if (result.ok !== pending_rsp[0].ok) begin
					$error("ok: expected %0d, got %0d", pending_rsp[0].ok, result.ok);
					errors++;
				end
				if (result.block_addr !== pending_rsp[0].block_addr) begin
					$error("block_addr: expected %0d, got %0d",
						pending_rsp[0].block_addr, result.block_addr);
					errors++;
				end
				if (result.data_pages_used !== pending_rsp[0].data_pages_used) begin
					$error("data_pages_used: expected %0d, got %0d",
						pending_rsp[0].data_pages_used, result.data_pages_used);
					errors++;
				end
				if (result.page_released !== pending_rsp[0].page_released) begin
					$error("page_released: expected %0d, got %0d",
						pending_rsp[0].page_released, result.page_released);
					errors++;
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	// Watchdog: counts cycles in which no word moves in either direction.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("FAIL power_of_two_free_list_allocator");
				$finish;
			end
		end
	end

	initial begin
		row_t rows [$];
		row_t rw;
		req_t w;
		int pick;
		int a;
		int roll;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		errors = 0;
		n_words = 0;
		n_allocs = 0;
		n_frees = 0;
		n_releases = 0;
		n_refused = 0;
		idle_cycles = 0;
		no_gaps = 1'b0;
		clear_shadow();

		// Free before any allocate, oversize allocate, smallest allocate and its free.
		rows.push_back('{KindFree, 0, 0, 1'b1, '{1'b0, 17'd0, 5'd0, 1'b0}});
		rows.push_back('{KindAlloc, 8191, 0, 1'b1, '{1'b0, 17'd0, 5'd0, 1'b0}});
		rows.push_back('{KindAlloc, 0, 0, 1'b1, '{1'b1, 17'd8232, 5'd1, 1'b0}});
		rows.push_back('{KindFree, 0, 8232, 1'b1, '{1'b1, 17'd0, 5'd0, 1'b1}});
		// Largest request that still fits a page.
		rows.push_back('{KindAlloc, 8152, 0, 1'b1, '{1'b1, 17'd8232, 5'd1, 1'b0}});
		rows.push_back('{KindAlloc, 8152, 0, 1'b1, '{1'b1, 17'd16424, 5'd2, 1'b0}});
		rows.push_back('{KindFree, 0, 8232, 1'b1, '{1'b1, 17'd0, 5'd1, 1'b1}});
		// Bad frees: returned page, misaligned, unused page, below the header.
		rows.push_back('{KindFree, 0, 8232, 1'b1, '{1'b0, 17'd0, 5'd1, 1'b0}});
		rows.push_back('{KindFree, 0, 16488, 1'b1, '{1'b0, 17'd0, 5'd1, 1'b0}});
		rows.push_back('{KindFree, 0, 131071, 1'b1, '{1'b0, 17'd0, 5'd1, 1'b0}});
		rows.push_back('{KindFree, 0, 39, 1'b1, '{1'b0, 17'd0, 5'd1, 1'b0}});
		rows.push_back('{KindAlloc, 24, 0, 1'b0, '0});
		rows.push_back('{KindAlloc, 25, 0, 1'b0, '0});
		// Fill the pool until it is exhausted.
		for (int k = 0; k < 13; k++) begin
			rows.push_back('{KindAlloc, 4096 + k * 300, 0, 1'b0, '0});
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			rw = rows[i];
			w.kind = rw.kind;
			w.req_bytes = 13'(rw.req);
			w.free_addr = 17'(rw.addr);
			issue(w, rw.typed, rw.want);
		end

		for (int n = 0; n < 600; n++) begin
			no_gaps = (n >= 200 && n < 350);
			if (n == 400) begin
				start <= 1'b0;
				wait (pending_rsp.size() == 0);
				@(posedge clk);
			end
			roll = $urandom_range(99);
			if (roll < 4) begin
				issue_checked($urandom_range(1), $urandom_range(8191), $urandom_range(131071));
			end else if (roll < 7 && dead_addr.size() > 0) begin
				// Free of a block that was already returned.
				issue_checked(KindFree, 0, dead_addr[$urandom_range(dead_addr.size() - 1)]);
			end else if (roll < 9 && live_addr.size() > 0) begin
				issue_checked(KindFree, 0, live_addr[0] + MinBlock * $urandom_range(1, 3));
			end else if (live_addr.size() > 0 && $urandom_range(99) < 15 + 3 * data_pages) begin
				pick = $urandom_range(live_addr.size() - 1);
				a = live_addr[pick];
				live_addr.delete(pick);
				dead_addr.push_back(a);
				if (dead_addr.size() > 32) begin
					void'(dead_addr.pop_front());
				end
				issue_checked(KindFree, 0, a);
			end else begin
				roll = $urandom_range(99);
				if (roll < 70) begin
					issue_checked(KindAlloc, $urandom_range(600), 0);
				end else if (roll < 95) begin
					issue_checked(KindAlloc, $urandom_range(8152), 0);
				end else begin
					issue_checked(KindAlloc, $urandom_range(8191), 0);
				end
			end
		end
		// Return what is left so the release path runs down to an empty pool.
		while (live_addr.size() > 0) begin
			a = live_addr.pop_back();
			issue_checked(KindFree, 0, a);
		end
		start <= 1'b0;

		wait (pending_rsp.size() == 0);
		repeat (20) @(posedge clk);
		$display("Covered %0d words: %0d allocates (%0d refused), %0d frees, %0d page returns.",
			n_words, n_allocs, n_refused, n_frees, n_releases);
		if (errors == 0 && pending_rsp.size() == 0) begin
			$display("PASS power_of_two_free_list_allocator");
		end else begin
			$display("FAIL power_of_two_free_list_allocator");
		end
		$finish;
	end

endmodule
